@@ hdl/spfp_pkg.sv @@
package spfp_pkg;

    // Header text "IMPROV" and frame layout
    localparam int unsigned HDR_LEN    = 6;
    localparam int unsigned OFS_VER    = 6;
    localparam int unsigned OFS_TYPE   = 7;
    localparam int unsigned OFS_LEN    = 8;
    localparam int unsigned OFS_CMD    = 9;
    localparam int unsigned OFS_NAME   = 11;
    localparam int unsigned FRAME_OVHD = 10;

    localparam logic [7:0] HDR_I = 8'h49;

    localparam logic [7:0] VERSION_ONE  = 8'h01;
    localparam logic [7:0] TYPE_RPC     = 8'h03;
    localparam logic [7:0] CMD_WIFI     = 8'h01;
    localparam logic [7:0] CMD_STATE    = 8'h02;
    localparam logic [7:0] CMD_INFO     = 8'h03;
    localparam logic [7:0] CMD_NETWORKS = 8'h04;
    localparam logic [7:0] MIN_RPC_LEN  = 8'd2;
    localparam logic [8:0] WIFI_OVHD    = 9'd4;

    // accept_code values
    localparam logic [1:0] ACC_OUTSIDE  = 2'd0;
    localparam logic [1:0] ACC_IN_FRAME = 2'd1;
    localparam logic [1:0] ACC_HEADER   = 2'd2;

    // verdict values
    localparam logic [2:0] VER_ACCEPTED  = 3'd0;
    localparam logic [2:0] VER_BAD_CSUM  = 3'd1;
    localparam logic [2:0] VER_SHORT_RPC = 3'd2;
    localparam logic [2:0] VER_MALFORMED = 3'd3;
    localparam logic [2:0] VER_UNKNOWN   = 3'd4;
    localparam logic [2:0] VER_NON_CMD   = 3'd5;

    typedef struct packed {
        logic [1:0] accept_code;
        logic       frame_dropped;
        logic       payload_valid;
        logic [7:0] payload_index;
        logic [7:0] payload_byte;
        logic       frame_done;
        logic [7:0] frame_type;
        logic [7:0] payload_length;
        logic [7:0] rpc_command;
        logic [2:0] verdict;
    } t_result;

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h49;
            3'd1:    c = 8'h4D;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h56;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/serial_provisioning_frame_parser.sv @@
// Serial provisioning frame parser.
// Input channel (i_valid / o_ready) carries one received serial byte per
// request in i_rx_byte. Output channel (o_valid / i_ready) returns exactly
// one result per input request: header progress, drop flag, payload byte
// with its index, and on the checksum byte the frame summary and verdict.
// Frame: "IMPROV", version (must be 1), type, length, payload, checksum.
// Results are registered; a result is presented the cycle after its byte
// is accepted unless earlier results still wait. One byte per cycle while
// o_ready is high; parsing is combinational from state to result register.
// A two-entry output stage (result register plus skid register) lets the
// parser take one more byte while a result waits; o_ready drops only when
// both entries are full, so a stalled receiver holds the input side after
// one extra byte and no result is lost or repeated.
// Reset (synchronous, active low) clears the byte position, running sum,
// captured fields and both output entries; header matching restarts.
// A frame longer than BUFFER_BYTES bytes is dropped on the byte that
// reaches the limit.
module serial_provisioning_frame_parser #(
    parameter int unsigned BUFFER_BYTES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_accept_code,
    output logic       o_frame_dropped,
    output logic       o_payload_valid,
    output logic [7:0] o_payload_index,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_done,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_payload_length,
    output logic [7:0] o_rpc_command,
    output logic [2:0] o_verdict
);

    // Position holds values up to BUFFER_BYTES - 1; one extra bit lets the
    // incremented value reach BUFFER_BYTES for the overflow compare.
    localparam int unsigned POS_W = $clog2(BUFFER_BYTES) + 1;
    localparam int unsigned CMP_W = ((POS_W > 9) ? POS_W : 9) + 1;

    // Frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_name, n_name;

    // Output stage
    spfp_pkg::t_result r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    logic             in_fire, out_fire;
    logic [POS_W-1:0] pos_inc;
    logic [CMP_W-1:0] pos_inc_x, at_x, total_x;
    logic             done, over;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_out_valid && i_ready;
    assign o_ready  = !r_skid_valid;

    assign pos_inc   = r_pos + POS_W'(1);
    assign pos_inc_x = CMP_W'(pos_inc);
    assign at_x      = CMP_W'(r_pos);

    // Parse one byte against the current frame state
    always_comb begin
        res     = '0;
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_type  = r_type;
        n_len   = r_len;
        n_cmd   = r_cmd;
        n_name  = r_name;
        total_x = '0;
        done    = 1'b0;
        over    = 1'b0;

        if (r_pos < POS_W'(spfp_pkg::HDR_LEN)) begin
            // Header match; a stray 'I' restarts at the second character
            if (i_rx_byte == spfp_pkg::hdr_char(r_pos[2:0])) begin
                n_sum = r_sum + i_rx_byte;
                n_pos = pos_inc;
                res.accept_code = (pos_inc == POS_W'(spfp_pkg::HDR_LEN)) ?
                    spfp_pkg::ACC_HEADER : spfp_pkg::ACC_OUTSIDE;
            end else if (i_rx_byte == spfp_pkg::HDR_I) begin
                n_sum = i_rx_byte;
                n_pos = POS_W'(1);
            end else begin
                n_sum = '0;
                n_pos = '0;
            end
        end else begin
            res.accept_code = spfp_pkg::ACC_IN_FRAME;
            if (r_pos == POS_W'(spfp_pkg::OFS_TYPE)) n_type = i_rx_byte;
            if (r_pos == POS_W'(spfp_pkg::OFS_LEN))  n_len  = i_rx_byte;
            if (r_pos == POS_W'(spfp_pkg::OFS_CMD))  n_cmd  = i_rx_byte;
            if (r_pos == POS_W'(spfp_pkg::OFS_NAME)) n_name = i_rx_byte;
            n_pos = pos_inc;

            if (r_pos == POS_W'(spfp_pkg::OFS_VER) && i_rx_byte != spfp_pkg::VERSION_ONE) begin
                // Drop on bad version
                res.frame_dropped = 1'b1;
                n_pos = '0;
                n_sum = '0;
            end else begin
                total_x = CMP_W'(spfp_pkg::FRAME_OVHD) + CMP_W'(n_len);
                if (at_x >= CMP_W'(spfp_pkg::OFS_CMD) &&
                    at_x < CMP_W'(spfp_pkg::OFS_CMD) + CMP_W'(n_len)) begin
                    res.payload_valid = 1'b1;
                    res.payload_index = 8'(r_pos - POS_W'(spfp_pkg::OFS_CMD));
                    res.payload_byte  = i_rx_byte;
                end
                done = (pos_inc_x >= CMP_W'(spfp_pkg::FRAME_OVHD)) &&
                       (pos_inc_x >= total_x);
                if (done) begin
                    res.frame_done     = 1'b1;
                    res.frame_type     = n_type;
                    res.payload_length = n_len;
                    res.rpc_command    = n_cmd;
                    priority if (r_sum != i_rx_byte) begin
                        res.verdict = spfp_pkg::VER_BAD_CSUM;
                    end else if (n_type != spfp_pkg::TYPE_RPC) begin
                        res.verdict = spfp_pkg::VER_NON_CMD;
                    end else if (n_len < spfp_pkg::MIN_RPC_LEN) begin
                        res.verdict = spfp_pkg::VER_SHORT_RPC;
                    end else if (n_cmd == spfp_pkg::CMD_WIFI) begin
                        res.verdict = (spfp_pkg::WIFI_OVHD + 9'(n_name) > 9'(n_len)) ?
                            spfp_pkg::VER_MALFORMED : spfp_pkg::VER_ACCEPTED;
                    end else if (n_cmd == spfp_pkg::CMD_STATE ||
                                 n_cmd == spfp_pkg::CMD_INFO ||
                                 n_cmd == spfp_pkg::CMD_NETWORKS) begin
                        res.verdict = spfp_pkg::VER_ACCEPTED;
                    end else begin
                        res.verdict = spfp_pkg::VER_UNKNOWN;
                    end
                    n_pos = '0;
                    n_sum = '0;
                end else begin
                    n_sum = r_sum + i_rx_byte;
                    // Drop when the frame fills the buffer
                    over = pos_inc_x >= CMP_W'(BUFFER_BYTES);
                    if (over) begin
                        res.frame_dropped = 1'b1;
                        n_pos = '0;
                        n_sum = '0;
                    end
                end
            end
        end
    end

    // Frame state advances on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_type <= '0;
            r_len  <= '0;
            r_cmd  <= '0;
            r_name <= '0;
        end else if (in_fire) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_type <= n_type;
            r_len  <= n_len;
            r_cmd  <= n_cmd;
            r_name <= n_name;
        end
    end

    // Output stage control: result register first, skid behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_fire;
                end
            end else if (!r_out_valid) begin
                r_out_valid <= in_fire;
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Output stage payload
    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (!r_out_valid) begin
            r_out <= res;
        end else if (in_fire) begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_accept_code    = r_out.accept_code;
    assign o_frame_dropped  = r_out.frame_dropped;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_index  = r_out.payload_index;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_frame_done     = r_out.frame_done;
    assign o_frame_type     = r_out.frame_type;
    assign o_payload_length = r_out.payload_length;
    assign o_rpc_command    = r_out.rpc_command;
    assign o_verdict        = r_out.verdict;

`ifndef ASSERT_OFF
    a_pos_in_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(BUFFER_BYTES))
        else $error("byte position beyond buffer");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without result entry");

    a_done_not_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_done && o_frame_dropped))
        else $error("frame both completed and dropped");

    a_payload_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_payload_valid || o_frame_done)) |->
            (o_accept_code == spfp_pkg::ACC_IN_FRAME))
        else $error("payload or completion outside a frame");

    a_restart_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && done) |=> (r_pos == '0 && r_sum == '0))
        else $error("parser did not restart after frame end");
`endif

endmodule

@@ dv/tb_serial_provisioning_frame_parser.sv @@
module tb_serial_provisioning_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BUF_BYTES   = 256;
    // Header text, first character in the top byte
    localparam logic [47:0] HDR_TEXT    = 48'h494D50524F56;
    // Stop adding random traffic to a phase once this many bytes are planned
    localparam int unsigned PHASE_BYTES = 24;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned DRAIN_LIMIT = 5000;

    // Predicts the result of every accepted byte and matches it against the
    // results in order. Keeps its own copy of the frame state.
    class frame_scoreboard;
        spfp_pkg::t_result expected_q[$];
        int unsigned       errors;
        logic [8:0]        frame_pos;
        logic [7:0]        frame_sum;
        logic [7:0]        cap_type;
        logic [7:0]        cap_length;
        logic [7:0]        cap_command;
        logic [7:0]        cap_name_len;

        function new();
            errors       = 0;
            frame_pos    = '0;
            frame_sum    = '0;
            cap_type     = '0;
            cap_length   = '0;
            cap_command  = '0;
            cap_name_len = '0;
        endfunction

        function void note_byte(logic [7:0] rx);
            spfp_pkg::t_result r;
            int unsigned       pos;
            int unsigned       at;
            r   = '0;
            pos = frame_pos;
            if (pos < spfp_pkg::HDR_LEN) begin
                if (rx == HDR_TEXT[47 - 8*pos -: 8]) begin
                    frame_sum += rx;
                    pos++;
                    r.accept_code = (pos == spfp_pkg::HDR_LEN) ? spfp_pkg::ACC_HEADER
                                                               : spfp_pkg::ACC_OUTSIDE;
                end else if (rx == spfp_pkg::HDR_I) begin
                    // a stray I opens a new header attempt
                    frame_sum = rx;
                    pos       = 1;
                end else begin
                    frame_sum = '0;
                    pos       = 0;
                end
            end else begin
                at            = pos;
                r.accept_code = spfp_pkg::ACC_IN_FRAME;
                case (at)
                    spfp_pkg::OFS_TYPE: cap_type     = rx;
                    spfp_pkg::OFS_LEN:  cap_length   = rx;
                    spfp_pkg::OFS_CMD:  cap_command  = rx;
                    spfp_pkg::OFS_NAME: cap_name_len = rx;
                    default: ;
                endcase
                pos++;
                if (at == spfp_pkg::OFS_VER && rx != spfp_pkg::VERSION_ONE) begin
                    r.frame_dropped = 1'b1;
                    pos             = 0;
                    frame_sum       = '0;
                end else begin
                    if (at >= spfp_pkg::OFS_CMD && at < spfp_pkg::OFS_CMD + cap_length) begin
                        r.payload_valid = 1'b1;
                        r.payload_index = 8'(at - spfp_pkg::OFS_CMD);
                        r.payload_byte  = rx;
                    end
                    if (pos >= spfp_pkg::FRAME_OVHD &&
                        pos >= spfp_pkg::FRAME_OVHD + cap_length) begin
                        // this byte is the checksum: close the frame
                        r.frame_done     = 1'b1;
                        r.frame_type     = cap_type;
                        r.payload_length = cap_length;
                        r.rpc_command    = cap_command;
                        if (frame_sum != rx)
                            r.verdict = spfp_pkg::VER_BAD_CSUM;
                        else if (cap_type != spfp_pkg::TYPE_RPC)
                            r.verdict = spfp_pkg::VER_NON_CMD;
                        else if (cap_length < spfp_pkg::MIN_RPC_LEN)
                            r.verdict = spfp_pkg::VER_SHORT_RPC;
                        else begin
                            case (cap_command)
                                spfp_pkg::CMD_WIFI:
                                    r.verdict = (9'(cap_name_len) + spfp_pkg::WIFI_OVHD >
                                                 9'(cap_length)) ? spfp_pkg::VER_MALFORMED
                                                                 : spfp_pkg::VER_ACCEPTED;
                                spfp_pkg::CMD_STATE, spfp_pkg::CMD_INFO,
                                spfp_pkg::CMD_NETWORKS:
                                    r.verdict = spfp_pkg::VER_ACCEPTED;
                                default:
                                    r.verdict = spfp_pkg::VER_UNKNOWN;
                            endcase
                        end
                        pos       = 0;
                        frame_sum = '0;
                    end else begin
                        frame_sum += rx;
                    end
                    if (pos >= BUF_BYTES) begin
                        r.frame_dropped = 1'b1;
                        pos             = 0;
                        frame_sum       = '0;
                    end
                end
            end
            frame_pos = 9'(pos);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(spfp_pkg::t_result got);
            spfp_pkg::t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no request pending, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("accept_code", 8'(want.accept_code), 8'(got.accept_code));
            compare_field("frame_dropped", 8'(want.frame_dropped), 8'(got.frame_dropped));
            compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
            compare_field("payload_index", want.payload_index, got.payload_index);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
            compare_field("frame_type", want.frame_type, got.frame_type);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("rpc_command", want.rpc_command, got.rpc_command);
            compare_field("verdict", 8'(want.verdict), 8'(got.verdict));
        endfunction
    endclass

    // All inputs start at known values; reset is held from time zero
    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = '0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_accept_code;
    logic       o_frame_dropped;
    logic       o_payload_valid;
    logic [7:0] o_payload_index;
    logic [7:0] o_payload_byte;
    logic       o_frame_done;
    logic [7:0] o_frame_type;
    logic [7:0] o_payload_length;
    logic [7:0] o_rpc_command;
    logic [2:0] o_verdict;

    int unsigned     send_idle_pct = 0;
    int unsigned     recv_idle_pct = 0;
    int unsigned     cycle_count   = 0;
    logic [7:0]      rx_plan[$];
    frame_scoreboard sb;

    serial_provisioning_frame_parser #(
        .BUFFER_BYTES(BUF_BYTES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_accept_code   (o_accept_code),
        .o_frame_dropped (o_frame_dropped),
        .o_payload_valid (o_payload_valid),
        .o_payload_index (o_payload_index),
        .o_payload_byte  (o_payload_byte),
        .o_frame_done    (o_frame_done),
        .o_frame_type    (o_frame_type),
        .o_payload_length(o_payload_length),
        .o_rpc_command   (o_rpc_command),
        .o_verdict       (o_verdict)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs on either side
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_serial_provisioning_frame_parser: done, errors");
            $finish;
        end
    end

    // Receiver: throttle ready at the current stall rate; one update per falling edge
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: sample both handshakes at the rising edge, before the block updates
    always @(posedge i_clk) begin : monitor
        spfp_pkg::t_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_byte(i_rx_byte);
            if (o_valid && i_ready) begin
                got = {o_accept_code, o_frame_dropped, o_payload_valid, o_payload_index,
                       o_payload_byte, o_frame_done, o_frame_type, o_payload_length,
                       o_rpc_command, o_verdict};
                sb.check_result(got);
            end
        end
    end

    // Queue one complete frame. The checksum covers header through payload;
    // a bad one is forced off by a nonzero xor.
    function automatic void push_frame(logic [7:0] ver, logic [7:0] ftype,
                                       logic [7:0] len, logic [7:0] cmd,
                                       logic [7:0] name_len, logic good_sum);
        logic [7:0] frame[$];
        logic [7:0] csum;
        csum = '0;
        for (int k = 0; k < spfp_pkg::HDR_LEN; k++)
            frame.push_back(HDR_TEXT[47 - 8*k -: 8]);
        frame.push_back(ver);
        frame.push_back(ftype);
        frame.push_back(len);
        for (int k = 0; k < len; k++)
            frame.push_back(k == 0 ? cmd : (k == 2 ? name_len : 8'($urandom_range(255))));
        foreach (frame[k])
            csum += frame[k];
        frame.push_back(good_sum ? csum : csum ^ 8'($urandom_range(1, 255)));
        rx_plan = {rx_plan, frame};
    endfunction

    // Mostly well-formed RPC frames with random content; a few bad versions,
    // foreign types and bad checksums mixed in.
    function automatic void random_frame();
        logic [7:0] ver;
        logic [7:0] ftype;
        logic [7:0] len;
        logic [7:0] cmd;
        int unsigned pick;
        ver   = ($urandom_range(99) < 8) ? ($urandom_range(1) ? 8'h00
                                            : 8'($urandom_range(2, 255)))
                                          : spfp_pkg::VERSION_ONE;
        ftype = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : spfp_pkg::TYPE_RPC;
        pick  = $urandom_range(99);
        if (pick < 70)
            len = 8'($urandom_range(0, 8));
        else if (pick < 95)
            len = 8'($urandom_range(9, 20));
        else
            len = 8'($urandom_range(21, 40));
        case ($urandom_range(6))
            0, 1:    cmd = spfp_pkg::CMD_WIFI;
            2:       cmd = spfp_pkg::CMD_STATE;
            3:       cmd = spfp_pkg::CMD_INFO;
            4:       cmd = spfp_pkg::CMD_NETWORKS;
            default: cmd = 8'($urandom_range(255));
        endcase
        // name length straddles the point where the settings stop fitting
        push_frame(ver, ftype, len, cmd, 8'($urandom_range(0, len + 1)),
                   $urandom_range(99) < 85);
    endfunction

    // Line noise: random bytes, broken headers, lone I characters
    function automatic void random_noise();
        int unsigned n;
        case ($urandom_range(3))
            0: begin
                n = $urandom_range(1, 3);
                repeat (n) rx_plan.push_back(8'($urandom_range(255)));
            end
            1, 2: begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    rx_plan.push_back(HDR_TEXT[47 - 8*k -: 8]);
                case ($urandom_range(2))
                    0: rx_plan.push_back(8'($urandom_range(255)));
                    1: rx_plan.push_back(spfp_pkg::HDR_I);
                    default: ;
                endcase
            end
            default: rx_plan.push_back(spfp_pkg::HDR_I);
        endcase
    endfunction

    // Offer one request; idle first at the sender rate, then hold valid and
    // data until the block takes it.
    task automatic send_byte(input logic [7:0] rx);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_plan();
        foreach (rx_plan[k])
            send_byte(rx_plan[k]);
        rx_plan.delete();
    endtask

    initial begin
        int unsigned drain;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                // Restart on a stray I inside the header, then a zero version
                // byte that drops the frame
                rx_plan = '{8'h49, 8'h4D, 8'h49, 8'h4D, 8'h50, 8'h52, 8'h4F, 8'h56,
                            8'h00, 8'hFF};
                // Zero-length RPC: the checksum doubles as the command byte
                push_frame(spfp_pkg::VERSION_ONE, spfp_pkg::TYPE_RPC, 8'd0, 8'h00, 8'h00,
                           1'b1);
            end

            while (rx_plan.size() < PHASE_BYTES) begin
                if ($urandom_range(3) != 0)
                    random_frame();
                else
                    random_noise();
            end

            // One long frame in each of the first two phases: exact fit in the buffer, then overflow
            if (phase == 0)
                push_frame(spfp_pkg::VERSION_ONE, spfp_pkg::TYPE_RPC,
                           8'(BUF_BYTES - spfp_pkg::FRAME_OVHD), spfp_pkg::CMD_WIFI,
                           8'($urandom_range(255)), 1'b1);
            else if (phase == 1)
                push_frame(spfp_pkg::VERSION_ONE, spfp_pkg::TYPE_RPC,
                           8'($urandom_range(BUF_BYTES - spfp_pkg::FRAME_OVHD + 1, 255)),
                           spfp_pkg::CMD_STATE, 8'h00, 1'b1);
            random_frame();

            send_plan();
        end

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain outstanding results, then give the skid stage time to misbehave
        drain = 0;
        while (sb.expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived, oldest %p",
                     $time, sb.expected_q.size(), sb.expected_q[0]);
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("tb_serial_provisioning_frame_parser: done, clean");
        else
            $display("tb_serial_provisioning_frame_parser: done, errors");
        $finish;
    end

endmodule
